// ===== hdl/swmv_pkg.sv =====
`default_nettype none

package swmv_pkg;

  // Fixed field widths of the register port and of the result word.
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 9;
  localparam int VAR_W   = 31;

  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_MUL_N_LOAD,
    ST_MUL_N,
    ST_MUL_S_LOAD,
    ST_MUL_S,
    ST_DIVM_LOAD,
    ST_DIVM,
    ST_DIVV_LOAD,
    ST_DIVV,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQUARE,
    OP_UPDATE,
    OP_MUL_N_LOAD,
    OP_MUL_S_LOAD,
    OP_MUL_STEP,
    OP_DIVM_LOAD,
    OP_DIV_STEP,
    OP_DIVV_LOAD,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic   take;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
    logic var_direct;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/swmv_datapath.sv =====
`default_nettype none

module swmv_datapath #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [swmv_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [SAMPLE_BITS-1:0]      sample_i,
  input  wire swmv_pkg::dp_cmd_t           cmd_i,
  output swmv_pkg::dp_status_t             status_o,
  output logic [SAMPLE_BITS-1:0]           mean_o,
  output logic [swmv_pkg::VAR_W-1:0]       variance_o,
  output logic [SAMPLE_BITS-1:0]           last_sample_o,
  output logic [swmv_pkg::COUNT_W-1:0]     sample_count_o
);
  import swmv_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int SUMW = SB + CW;
  localparam int SQW  = 2 * SB + CW;
  localparam int DW   = (2 * SB + 2 * CW > 33) ? 2 * SB + 2 * CW : 33;
  localparam int DNW  = 2 * CW;
  localparam int QW   = (SUMW > VAR_W) ? SUMW : VAR_W;
  localparam int CNTW = $clog2(QW + 1);
  localparam int LW   = (CFG_W > CW) ? CFG_W : CW;

  // Window state.
  logic [CW-1:0]          len_q;
  logic [CW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic [SQW-1:0]         sumsq_q, sumsq_d;

  // Item payload.
  logic [SB-1:0]          ring_q [WINDOW_MAX];
  logic signed [SB-1:0]   sample_q;
  logic signed [SB-1:0]   rd_q;
  logic signed [SB-1:0]   old_q;
  logic [AW-1:0]          pos_q;
  logic                   full_q;
  logic [2*SB-1:0]        sq_new_q;
  logic [2*SB-1:0]        sq_old_q;

  // Shared shift-add multiplier and restoring divider.
  logic [DW:0]            acc_q;
  logic [DW-1:0]          mcand_q;
  logic [SUMW-1:0]        mplier_q;
  logic                   sub_q;
  logic [DNW-1:0]         den_q;
  logic [DNW-1:0]         rem_q;
  logic [QW-1:0]          dvd_q;
  logic [DNW-1:0]         div_q;
  logic [CNTW-1:0]        cnt_q;
  logic                   neg_q;
  logic [SB-1:0]          mean_q;
  logic                   var_fix_q;
  logic [VAR_W-1:0]       var_val_q;

  logic [AW-1:0]          pos_w;
  logic [CW-1:0]          pos_inc;
  logic [LW-1:0]          cfg_val, cfg_len;
  logic                   cfg_apply;
  logic [SUMW-1:0]        mag;
  logic [DW:0]            mc_ext;
  logic [DNW:0]           rem_sh;
  logic                   rem_ge;
  logic [DW-32:0]         var_hi;
  logic                   var_neg, var_sat;
  logic [SUMW-1:0]        mean_mag;

  assign pos_w   = (CW'(wp_q) < len_q) ? wp_q : '0;
  assign pos_inc = CW'(pos_q) + CW'(1);

  assign cfg_val   = LW'(cfg_wdata_i);
  assign cfg_len   = (cfg_val > LW'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : cfg_val;
  assign cfg_apply = cfg_we_i && (cfg_val != '0) && (cfg_len != LW'(len_q));

  assign mag    = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign mc_ext = (DW+1)'(mcand_q);
  assign rem_sh = {rem_q, dvd_q[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_q};

  assign var_hi  = acc_q[DW-1:31];
  assign var_neg = acc_q[DW];
  assign var_sat = var_hi >= den_q;

  assign mean_mag = dvd_q[SUMW-1:0];

  assign status_o.step_last  = (cnt_q == CNTW'(1));
  assign status_o.var_direct = var_neg || var_sat;

  always_comb begin
    fill_d  = full_q ? len_q : fill_q + CW'(1);
    wp_d    = (pos_inc >= len_q) ? '0 : AW'(pos_inc);
    sum_d   = sum_q - SUMW'(old_q) + SUMW'(sample_q);
    sumsq_d = sumsq_q - SQW'(sq_old_q) + SQW'(sq_new_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= CW'(WINDOW_MAX);
      fill_q  <= '0;
      wp_q    <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (cfg_apply) begin
      len_q   <= CW'(cfg_len);
      fill_q  <= '0;
      wp_q    <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (cmd_i.op == OP_UPDATE) begin
      fill_q  <= fill_d;
      wp_q    <= wp_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
    end
  end

  // Sample ring, one read when a word is taken and one write at update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_q <= ring_q[pos_w];
    end
    if (cmd_i.op == OP_UPDATE) begin
      ring_q[pos_q] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_i;
      pos_q    <= pos_w;
      full_q   <= (fill_q >= len_q);
    end
    case (cmd_i.op)
      OP_SQUARE: begin
        old_q    <= full_q ? rd_q : '0;
        sq_old_q <= full_q ? (2*SB)'(rd_q) * (2*SB)'(rd_q) : '0;
        sq_new_q <= (2*SB)'(sample_q) * (2*SB)'(sample_q);
      end
      OP_MUL_N_LOAD: begin
        acc_q    <= '0;
        mcand_q  <= DW'(sumsq_q);
        mplier_q <= SUMW'(fill_q);
        sub_q    <= 1'b0;
        cnt_q    <= CNTW'(CW);
        den_q    <= DNW'(fill_q) * DNW'(fill_q);
      end
      OP_MUL_S_LOAD: begin
        mcand_q  <= DW'(mag);
        mplier_q <= mag;
        sub_q    <= 1'b1;
        cnt_q    <= CNTW'(SUMW);
      end
      OP_MUL_STEP: begin
        if (mplier_q[0]) begin
          acc_q <= sub_q ? acc_q - mc_ext : acc_q + mc_ext;
        end
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CNTW'(1);
      end
      OP_DIVM_LOAD: begin
        neg_q <= sum_q[SUMW-1];
        rem_q <= '0;
        dvd_q <= QW'(mag) << (QW - SUMW);
        div_q <= DNW'(fill_q);
        cnt_q <= CNTW'(SUMW);
      end
      OP_DIV_STEP: begin
        rem_q <= rem_ge ? DNW'(rem_sh - {1'b0, div_q}) : DNW'(rem_sh);
        dvd_q <= {dvd_q[QW-2:0], rem_ge};
        cnt_q <= cnt_q - CNTW'(1);
      end
      OP_DIVV_LOAD: begin
        mean_q    <= neg_q ? SB'(~mean_mag + 1'b1) : SB'(mean_mag);
        var_fix_q <= var_neg || var_sat;
        var_val_q <= var_neg ? '0 : VAR_MAX;
        rem_q     <= DNW'(var_hi);
        dvd_q     <= QW'(acc_q[30:0]) << (QW - VAR_W);
        div_q     <= den_q;
        cnt_q     <= CNTW'(VAR_W);
      end
      OP_FINISH: begin
        mean_o         <= mean_q;
        variance_o     <= var_fix_q ? var_val_q : dvd_q[VAR_W-1:0];
        last_sample_o  <= sample_q;
        sample_count_o <= COUNT_W'(fill_q);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/swmv_ctrl.sv =====
`default_nettype none

module swmv_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire swmv_pkg::dp_status_t status_i,
  output swmv_pkg::dp_cmd_t         cmd_o
);
  import swmv_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The result register can be reloaded once the previous word is gone.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE:     state_d = ST_UPDATE;
      ST_UPDATE:     state_d = ST_MUL_N_LOAD;
      ST_MUL_N_LOAD: state_d = ST_MUL_N;
      ST_MUL_N:      if (status_i.step_last) state_d = ST_MUL_S_LOAD;
      ST_MUL_S_LOAD: state_d = ST_MUL_S;
      ST_MUL_S:      if (status_i.step_last) state_d = ST_DIVM_LOAD;
      ST_DIVM_LOAD:  state_d = ST_DIVM;
      ST_DIVM:       if (status_i.step_last) state_d = ST_DIVV_LOAD;
      ST_DIVV_LOAD:  state_d = status_i.var_direct ? ST_FINISH : ST_DIVV;
      ST_DIVV:       if (status_i.step_last) state_d = ST_FINISH;
      ST_FINISH:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.take  = 1'b0;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE:       cmd_o.take = in_valid_i;
      ST_SQUARE:     cmd_o.op = OP_SQUARE;
      ST_UPDATE:     cmd_o.op = OP_UPDATE;
      ST_MUL_N_LOAD: cmd_o.op = OP_MUL_N_LOAD;
      ST_MUL_N:      cmd_o.op = OP_MUL_STEP;
      ST_MUL_S_LOAD: cmd_o.op = OP_MUL_S_LOAD;
      ST_MUL_S:      cmd_o.op = OP_MUL_STEP;
      ST_DIVM_LOAD:  cmd_o.op = OP_DIVM_LOAD;
      ST_DIVM:       cmd_o.op = OP_DIV_STEP;
      ST_DIVV_LOAD:  cmd_o.op = OP_DIVV_LOAD;
      ST_DIVV:       cmd_o.op = OP_DIV_STEP;
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/sliding_window_mean_variance.sv =====
// Channel  | Direction | Payload                                      | Handshake
// -------- | --------- | -------------------------------------------- | -------------------------
// input    | in        | sample_i                                     | in_valid_i / in_stall_o
// output   | out       | mean_o, variance_o, last_sample_o,           | out_valid_o / out_stall_i
//          |           | sample_count_o                               |
// config   | in        | cfg_wdata_i (window length)                  | cfg_we_i, no wait
//
// One word is worked on at a time. How long a word takes from acceptance to the next
// acceptance is set by the bit-serial shift-add multiplier and the restoring divider that
// run in turn. The variance division is skipped only when the numerator is negative or
// the variance saturates, which wider parameters allow.
// Reset clears the window and sets the window length to WINDOW_MAX; the ring contents
// are never read before they are written, so they need no clearing pass.
// A finished result waits in the output register while out_stall_i is high; the block
// goes on with the next word and only holds its last step until that register is free.

`default_nettype none

module sliding_window_mean_variance #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [swmv_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]      sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [SAMPLE_BITS-1:0]           mean_o,
  output logic [swmv_pkg::VAR_W-1:0]       variance_o,
  output logic [SAMPLE_BITS-1:0]           last_sample_o,
  output logic [swmv_pkg::COUNT_W-1:0]     sample_count_o
);
  import swmv_pkg::*;

  // The controller only sequences; all arithmetic and the sample ring sit in the
  // datapath. They talk through one command word and one status word.
  dp_cmd_t    cmd;
  dp_status_t status;

  swmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath keeps exact running sums, so the variance numerator
  // n*sumsq - sum^2 is computed without loss and then divided by n^2.
  swmv_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .mean_o         (mean_o),
    .variance_o     (variance_o),
    .last_sample_o  (last_sample_o),
    .sample_count_o (sample_count_o)
  );

endmodule

`default_nettype wire

// ===== hdl/swmv_checker.sv =====
`default_nettype none

module swmv_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [SAMPLE_BITS-1:0]      mean_o,
  input wire logic [swmv_pkg::VAR_W-1:0]  variance_o,
  input wire logic [SAMPLE_BITS-1:0]      last_sample_o,
  input wire logic [swmv_pkg::COUNT_W-1:0] sample_count_o
);
  import swmv_pkg::*;

  // A taken word keeps the input side busy in the following cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_o) &&
    $stable(variance_o) && $stable(last_sample_o) && $stable(sample_count_o))
    else $error("stalled result changed");

  // Every result covers at least the word that produced it.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0)
    else $error("result with an empty window");

  // A window of one sample has no spread.
  a_single_variance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_count_o == COUNT_W'(1) |-> variance_o == '0)
    else $error("nonzero variance for a single sample");

endmodule

bind sliding_window_mean_variance swmv_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swmv_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

// Self-checking bench for the sliding window mean and variance block.
// A behavioral copy of the window (ring, fill level, exact sums) runs beside the
// block. Every accepted sample word pushes the predicted statistics into a queue,
// and every accepted result word is compared field by field with the queue head.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swmv_pkg::*;

  localparam int WINDOW_MAX     = 256;
  localparam int SAMPLE_BITS    = 16;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 10;
  // This limit is far beyond any correct run.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 120;
  localparam int PRESSURE_HOLD  = 600;
  localparam int PRINT_LIMIT    = 40;
  localparam int SEGMENT_WORDS  = 350;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [VAR_W-1:0]              variance;
    logic signed [SAMPLE_BITS-1:0] last_sample;
    logic [COUNT_W-1:0]            sample_count;
  } window_stats_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] sample_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [SAMPLE_BITS-1:0] mean_o;
  logic [VAR_W-1:0]       variance_o;
  logic [SAMPLE_BITS-1:0] last_sample_o;
  logic [COUNT_W-1:0]     sample_count_o;

  sliding_window_mean_variance #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mean_o        (mean_o),
    .variance_o    (variance_o),
    .last_sample_o (last_sample_o),
    .sample_count_o(sample_count_o)
  );

  // The bench's own copy of the window. Only entries below the fill level are
  // ever read back, exactly as in the block.
  int     ring_copy [WINDOW_MAX];
  int     window_len;
  int     write_pos;
  int     fill_level;
  longint sum_samples;
  longint sum_squares;

  window_stats_t window_stats_q[$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Cycle counter and watchdog. A hang anywhere ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // A window length write as the block treats it: zero is dropped, values over
  // the ring depth saturate, rewriting the current length keeps the window,
  // and any real change empties the window.
  function automatic void apply_window_length(input logic [CFG_W-1:0] value);
    int len;
    len = int'(value);
    if (len == 0) return;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    if (len == window_len) return;
    window_len  = len;
    write_pos   = 0;
    fill_level  = 0;
    sum_samples = 0;
    sum_squares = 0;
  endfunction

  // Takes one sample into the window copy and returns the statistics the block
  // must report for it.
  function automatic window_stats_t advance_window(input logic signed [SAMPLE_BITS-1:0] s);
    longint        oldest;
    longint        spread;
    longint        quot;
    window_stats_t r;
    if (fill_level >= window_len) begin
      // Window is full: the entry about to be overwritten leaves both sums.
      oldest      = ring_copy[write_pos];
      sum_samples = sum_samples - oldest;
      sum_squares = sum_squares - oldest * oldest;
    end else begin
      fill_level++;
    end
    ring_copy[write_pos] = s;
    sum_samples = sum_samples + longint'(s);
    sum_squares = sum_squares + longint'(s) * longint'(s);
    write_pos   = (write_pos + 1 >= window_len) ? 0 : write_pos + 1;

    // Signed integer division truncates toward zero, as the mean requires.
    r.mean = SAMPLE_BITS'(sum_samples / longint'(fill_level));
    // n*sumsq - sum^2 stays below 2^47 here, so plain 64-bit math is exact.
    spread = longint'(fill_level) * sum_squares - sum_samples * sum_samples;
    if (spread <= 0) begin
      r.variance = '0;
    end else begin
      quot = spread / (longint'(fill_level) * longint'(fill_level));
      r.variance = (quot > longint'(VAR_MAX)) ? VAR_MAX : VAR_W'(quot);
    end
    r.last_sample  = s;
    r.sample_count = COUNT_W'(fill_level);
    return r;
  endfunction

  // Offers one sample word. Entered and left at a falling edge. The valid line
  // is only lowered when the sender really idles, so back-to-back words keep it
  // high without a glitch.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      sample_i   = SAMPLE_BITS'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    window_stats_q.push_back(advance_window(s));
    @(negedge clk_i);
  endtask

  // Stops offering words and waits until every predicted result has come back.
  task automatic wait_drained(input int extra_cycles);
    in_valid_i = 1'b0;
    while (window_stats_q.size() != 0) @(negedge clk_i);
    repeat (extra_cycles) @(negedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_window_length(input logic [CFG_W-1:0] value);
    wait_drained(SETTLE_CYCLES);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = CFG_W'($urandom);
    apply_window_length(value);
  endtask

  // Random samples: half are a per-segment level or noise around it (so the variance
  // stays small or hits zero), the rest full-range values and the extremes.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input logic signed [SAMPLE_BITS-1:0] level);
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return level;
      3, 4: return level + SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Result side: one stall process, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i = 1'b0;
    end else if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      out_stall_i  = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    window_stats_t exp_stats;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (window_stats_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending (mean %0d count %0d)",
                                  $signed(mean_o), sample_count_o));
      end else begin
        exp_stats = window_stats_q[0];
        window_stats_q.delete(0);
        if (mean_o !== exp_stats.mean)
          report_mismatch($sformatf("mean %0d, predicted %0d",
                                    $signed(mean_o), exp_stats.mean));
        if (variance_o !== exp_stats.variance)
          report_mismatch($sformatf("variance %0d, predicted %0d",
                                    variance_o, exp_stats.variance));
        if (last_sample_o !== exp_stats.last_sample)
          report_mismatch($sformatf("last_sample %0d, predicted %0d",
                                    $signed(last_sample_o), exp_stats.last_sample));
        if (sample_count_o !== exp_stats.sample_count)
          report_mismatch($sformatf("sample_count %0d, predicted %0d",
                                    sample_count_o, exp_stats.sample_count));
      end
    end
  end

  // Straight after reset the window length is the ring depth. Field extremes,
  // alternating bit patterns and the largest possible spread.
  task automatic test_reset_extremes();
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sh0001);
    send_sample(SAMPLE_MIN);
  endtask

  // Window length writes: single-entry window, rewriting the same length (the
  // window must survive), a wrap with length two, a dropped zero write, a
  // saturating oversized value and a change back to a short window.
  task automatic test_window_length_writes();
    write_window_length(CFG_W'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    write_window_length(CFG_W'(1));
    send_sample(16'sh0100);
    write_window_length(CFG_W'(2));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    write_window_length('0);
    send_sample(16'shFF00);
    write_window_length(CFG_W'(300));
    send_sample(16'sh7F00);
    send_sample(16'sh8100);
    write_window_length('1);
    send_sample(16'sh0080);
    write_window_length(CFG_W'(3));
    send_sample(16'sh0003);
    send_sample(16'shFFFD);
    send_sample(16'sh0003);
    send_sample(16'sh0003);
  endtask

  // One random phase: a short window that wraps many times, a full-depth window
  // long enough to wrap, then an arbitrary register value (which may be zero or
  // oversized) with a few more words.
  task automatic run_random_phase();
    logic signed [SAMPLE_BITS-1:0] level;
    level = SAMPLE_BITS'($urandom);
    write_window_length(CFG_W'($urandom_range(2, 12)));
    repeat (SEGMENT_WORDS / 6) send_sample(pick_sample(level));
    level = SAMPLE_BITS'($urandom);
    write_window_length(($urandom_range(1) == 0) ? CFG_W'(WINDOW_MAX)
                                                 : CFG_W'($urandom_range(257, 511)));
    repeat (SEGMENT_WORDS * 3 / 4) send_sample(pick_sample(level));
    level = SAMPLE_BITS'($urandom);
    write_window_length(CFG_W'($urandom_range(0, 511)));
    repeat (SEGMENT_WORDS - SEGMENT_WORDS / 6 - SEGMENT_WORDS * 3 / 4)
      send_sample(pick_sample(level));
  endtask

  // Random words under each idling pattern in turn.
  task automatic test_random_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_phase();
    send_idle_pct = 51;
    stall_pct     = 0;
    run_random_phase();
    send_idle_pct = 0;
    stall_pct     = 51;
    run_random_phase();
    send_idle_pct = 14;
    stall_pct     = 14;
    run_random_phase();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // words, so the output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_window_length(CFG_W'(5));
    hold_request = PRESSURE_HOLD;
    repeat (10) send_sample(pick_sample(SAMPLE_BITS'($urandom)));
  endtask

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 0;
    hold_left     = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    out_stall_i   = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) ring_copy[i] = 0;
    window_len  = WINDOW_MAX;
    write_pos   = 0;
    fill_level  = 0;
    sum_samples = 0;
    sum_squares = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_extremes();
    test_window_length_writes();
    test_random_traffic();
    test_output_backpressure();

    // Let any stray result word show up before the verdict.
    wait_drained(END_CYCLES);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sliding_window_mean_variance.f =====
hdl/swmv_pkg.sv
hdl/swmv_datapath.sv
hdl/swmv_ctrl.sv
hdl/sliding_window_mean_variance.sv
hdl/swmv_checker.sv
bench/testbench.sv
